// ----- sv/cycle_sort_with_duplicates_macros.svh -----
// assertion macros for the cycle sort block
// used by the sequencer module; no other dependencies
`ifndef CYCLE_SORT_WITH_DUPLICATES_MACROS_SVH
`define CYCLE_SORT_WITH_DUPLICATES_MACROS_SVH

// same-cycle implication, disabled while in reset
`define CSD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define CSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/csd_pkg.sv -----
// shared types, constants and the signed compare for the cycle sort block
// no dependencies
`default_nettype none

package csd_pkg;

    localparam int VALUE_W = 32;
    localparam int WCNT_W  = 7;
    localparam logic [WCNT_W-1:0] WRITE_MAX = {WCNT_W{1'b1}};

    // sequencer states
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_START_RD,
        ST_START_CAP,
        ST_SCAN,
        ST_SKIP_RD,
        ST_SKIP_CHK,
        ST_SWAP_RD,
        ST_SWAP_WR,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

    // result request from the sequencer to the output register
    typedef struct packed {
        logic              load;
        logic              final_item;
        logic [WCNT_W-1:0] writes;
        logic              ovf;
    } t_emit;

    // signed less-than on two's complement patterns
    function automatic logic csd_lt(input logic [VALUE_W-1:0] a,
                                    input logic [VALUE_W-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

endpackage

`default_nettype wire

// ----- sv/csd_mem.sv -----
// element store: one write port, one read port with registered read data
// depends on csd_pkg for the value width
`default_nettype none

module csd_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_wr_en,
    input  wire logic [AW-1:0]               i_wr_addr,
    input  wire logic [csd_pkg::VALUE_W-1:0] i_wr_data,
    input  wire logic [AW-1:0]               i_rd_addr,
    output logic      [csd_pkg::VALUE_W-1:0] o_rd_data
);
    import csd_pkg::*;

    logic [VALUE_W-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ----- sv/csd_seq.sv -----
// sequencer for load, cycle sort and emission over the element store
// depends on csd_pkg and the assertion macro header
`default_nettype none
`include "cycle_sort_with_duplicates_macros.svh"

module csd_seq #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int CW    = 7
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [csd_pkg::VALUE_W-1:0] i_sample_value,
    input  wire logic                        i_is_last,
    output logic                             o_wr_en,
    output logic      [AW-1:0]               o_wr_addr,
    output logic      [csd_pkg::VALUE_W-1:0] o_wr_data,
    output logic      [AW-1:0]               o_rd_addr,
    input  wire logic [csd_pkg::VALUE_W-1:0] i_rd_data,
    input  wire logic                        i_out_free,
    output csd_pkg::t_emit                   o_emit
);
    import csd_pkg::*;

    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic               r_ovf, n_ovf;
    logic [WCNT_W-1:0]  r_writes, n_writes;
    logic               r_pend, n_pend;
    logic               r_first, n_first;
    logic [CW-1:0]      r_start, n_start;
    logic [CW-1:0]      r_pos, n_pos;
    logic [CW-1:0]      r_idx, n_idx;
    logic [VALUE_W-1:0] r_item, n_item;
    logic [CW-1:0]      rd_addr;
    logic               in_acc;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_LOAD);
    assign o_rd_addr  = rd_addr[AW-1:0];

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_writes <= '0;
            r_pend   <= 1'b0;
            r_first  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_writes <= n_writes;
            r_pend   <= n_pend;
            r_first  <= n_first;
        end
    end

    // sort indexes and the item in hand
    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_pos   <= n_pos;
        r_idx   <= n_idx;
        r_item  <= n_item;
    end

    // next state, store access and result requests
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ovf    = r_ovf;
        n_writes = r_writes;
        n_pend   = r_pend;
        n_first  = r_first;
        n_start  = r_start;
        n_pos    = r_pos;
        n_idx    = r_idx;
        n_item   = r_item;
        rd_addr  = r_pos;
        o_wr_en   = 1'b0;
        o_wr_addr = r_count[AW-1:0];
        o_wr_data = i_sample_value;
        o_emit.load       = 1'b0;
        o_emit.final_item = 1'b0;
        o_emit.writes     = r_writes;
        o_emit.ovf        = r_ovf;

        unique case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    if (r_count < DEPTH_C) begin
                        o_wr_en = 1'b1;
                        n_count = r_count + ONE_C;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_is_last) begin
                        n_start  = '0;
                        n_writes = '0;
                        n_state  = ST_START_RD;
                    end
                end
            end
            ST_START_RD: begin
                rd_addr = r_start;
                if (r_start + ONE_C >= r_count) begin
                    n_idx   = '0;
                    n_state = ST_EMIT_RD;
                end else begin
                    n_state = ST_START_CAP;
                end
            end
            ST_START_CAP: begin
                n_item  = i_rd_data;
                n_first = 1'b1;
                n_pos   = r_start;
                n_idx   = r_start + ONE_C;
                n_pend  = 1'b0;
                n_state = ST_SCAN;
            end
            // count the smaller elements right of the cycle start
            ST_SCAN: begin
                rd_addr = r_idx;
                if (r_pend && csd_lt(i_rd_data, r_item)) begin
                    n_pos = r_pos + ONE_C;
                end
                if (r_idx < r_count) begin
                    n_idx  = r_idx + ONE_C;
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        if (r_first && r_pos == r_start) begin
                            n_start = r_start + ONE_C;
                            n_state = ST_START_RD;
                        end else begin
                            n_state = ST_SKIP_RD;
                        end
                    end
                end
            end
            // step past equal elements, never beyond the last held one
            ST_SKIP_RD: begin
                rd_addr = r_pos;
                if (r_pos + ONE_C < r_count) begin
                    n_state = ST_SKIP_CHK;
                end else begin
                    n_state = ST_SWAP_RD;
                end
            end
            ST_SKIP_CHK: begin
                rd_addr = r_pos;
                if (i_rd_data == r_item) begin
                    n_pos   = r_pos + ONE_C;
                    n_state = ST_SKIP_RD;
                end else begin
                    n_state = ST_SWAP_RD;
                end
            end
            ST_SWAP_RD: begin
                rd_addr = r_pos;
                n_state = ST_SWAP_WR;
            end
            // place the item and pick up the one it displaces
            ST_SWAP_WR: begin
                rd_addr = r_pos;
                if (r_first || i_rd_data != r_item) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_pos[AW-1:0];
                    o_wr_data = r_item;
                    n_item    = i_rd_data;
                    if (r_writes != WRITE_MAX) begin
                        n_writes = r_writes + WCNT_W'(1);
                    end
                end
                n_first = 1'b0;
                if (r_pos == r_start) begin
                    n_start = r_start + ONE_C;
                    n_state = ST_START_RD;
                end else begin
                    n_pos   = r_start;
                    n_idx   = r_start + ONE_C;
                    n_pend  = 1'b0;
                    n_state = ST_SCAN;
                end
            end
            ST_EMIT_RD: begin
                rd_addr = r_idx;
                n_state = ST_EMIT_LD;
            end
            // hand one sorted item to the output register
            ST_EMIT_LD: begin
                rd_addr = r_idx;
                if (i_out_free) begin
                    o_emit.load       = 1'b1;
                    o_emit.final_item = (r_idx + ONE_C == r_count);
                    if (r_idx + ONE_C == r_count) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = ST_LOAD;
                    end else begin
                        n_idx   = r_idx + ONE_C;
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // checks on the sequencer
    `CSD_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= DEPTH_C,
        "element count beyond store depth")
    `CSD_ASSERT_NOW(a_emit_free, i_clk, i_rst_n, o_emit.load,
        i_out_free && r_state == ST_EMIT_LD, "result loaded while output busy")
    `CSD_ASSERT_NOW(a_swap_pos, i_clk, i_rst_n, r_state == ST_SWAP_WR,
        r_pos < r_count && r_pos >= r_start, "swap position outside held set")
    `CSD_ASSERT_NEXT(a_final_clear, i_clk, i_rst_n, o_emit.load && o_emit.final_item,
        r_state == ST_LOAD && r_count == '0 && !r_ovf, "set not cleared after final item")

endmodule

`default_nettype wire

// ----- sv/cycle_sort_with_duplicates.sv -----
// cycle sort with duplicate handling over a store of DEPTH signed 32-bit values
// load: one item per cycle; the item marked last starts the sort of n held values
// sort: each cycle start is read and scanned against the values right of it; each placement
// skips equal values, and each placement after the first of a cycle rescans from the start
// emission: one result at a time; input is stalled from the last item to the final result
// synchronous active-low reset clears counters and flags; the store is not cleared
`default_nettype none

module cycle_sort_with_duplicates #(
    parameter int DEPTH = 64
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic signed [csd_pkg::VALUE_W-1:0] i_sample_value,
    input  wire logic                               i_is_last,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic signed      [csd_pkg::VALUE_W-1:0] o_sorted_value,
    output logic                                    o_is_final,
    output logic             [csd_pkg::WCNT_W-1:0]  o_write_count,
    output logic                                    o_overflowed
);
    import csd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic [AW-1:0]      rd_addr;
    logic [VALUE_W-1:0] rd_data;
    logic               out_free;
    t_emit              emit;

    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_final;
    logic [WCNT_W-1:0]  r_out_writes;
    logic               r_out_ovf;

    csd_mem #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_mem (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    csd_seq #(
        .DEPTH(DEPTH),
        .AW   (AW),
        .CW   (CW)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_sample_value($unsigned(i_sample_value)),
        .i_is_last     (i_is_last),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data),
        .i_out_free    (out_free),
        .o_emit        (emit)
    );

    assign out_free = !r_out_valid || !i_out_stall;

    // output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload, held while stalled
    always_ff @(posedge i_clk) begin
        if (emit.load) begin
            r_out_value  <= rd_data;
            r_out_final  <= emit.final_item;
            r_out_writes <= emit.writes;
            r_out_ovf    <= emit.ovf;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sorted_value = $signed(r_out_value);
    assign o_is_final     = r_out_final;
    assign o_write_count  = r_out_writes;
    assign o_overflowed   = r_out_ovf;

endmodule

`default_nettype wire
